// File: hdl/ttw_pkg.sv
// Shared types, codes and constants of the text terminal writer.
`default_nettype none

package ttw_pkg;

    // Item command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // Character codes
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_AT    = 8'h40;

    // Colour the store holds after reset
    localparam logic [7:0] RESET_COLOUR = 8'd1;

    // One cell word: colour in the upper byte, character in the lower byte
    localparam int CELL_W = 16;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_COLUMNS      = 3'd0;
    localparam logic [2:0] REG_ROWS         = 3'd1;
    localparam logic [2:0] REG_COLOUR       = 3'd2;
    localparam logic [2:0] REG_BLINK_ENABLE = 3'd3;
    localparam logic [2:0] REG_BLINK_PERIOD = 3'd4;

    localparam logic [7:0]  RST_COLUMNS      = 8'd80;
    localparam logic [6:0]  RST_ROWS         = 7'd25;
    localparam logic [7:0]  RST_COLOUR       = 8'd1;
    localparam logic        RST_BLINK_ENABLE = 1'b1;
    localparam logic [15:0] RST_BLINK_PERIOD = 16'd20;

    typedef struct packed {
        logic [7:0]  screen_columns;
        logic [6:0]  screen_rows;
        logic [7:0]  text_colour;
        logic        blink_enable;
        logic [15:0] blink_period;
    } cfg_t;

    typedef enum logic [2:0] {
        CUR_HOLD  = 3'd0,
        CUR_CLAMP = 3'd1,
        CUR_HOME  = 3'd2,
        CUR_COL0  = 3'd3,
        CUR_LEFT  = 3'd4,
        CUR_DOWN  = 3'd5,
        CUR_ADV   = 3'd6
    } cur_op_t;

    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_CHAR   = 3'd1,
        WR_CARET  = 3'd2,
        WR_CARET2 = 3'd3,
        WR_FILL   = 3'd4,
        WR_CLEAR  = 3'd5,
        WR_INIT   = 3'd6
    } wr_sel_t;

    typedef enum logic {
        RD_CELL = 1'b0,
        RD_COPY = 1'b1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WALK_HOLD      = 2'd0,
        WALK_START     = 2'd1,
        WALK_STEP      = 2'd2,
        WALK_STEP_FULL = 2'd3
    } walk_op_t;

    typedef enum logic [1:0] {
        BLINK_HOLD    = 2'd0,
        BLINK_RESTART = 2'd1,
        BLINK_TICK    = 2'd2
    } blink_op_t;

    // Controller to datapath
    typedef struct packed {
        logic      item_load;
        cur_op_t   cur_op;
        wr_sel_t   wr_sel;
        rd_sel_t   rd_sel;
        logic      copy_step;
        walk_op_t  walk_op;
        blink_op_t blink_op;
        logic      rd_capture;
        logic      out_load;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       is_cr;
        logic       is_lf;
        logic       is_bs;
        logic       is_ctrl;
        logic       at_last_col;
        logic       at_last_row;
        logic       last_row_zero;
        logic       walk_end_col;
        logic       walk_end_copy;
        logic       walk_end_clear;
        logic       walk_end_init;
        logic       out_free;
    } ctl_stat_t;

endpackage

`default_nettype wire

// File: hdl/ttw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/ttw_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module ttw_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ttw_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [ttw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [ttw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready,
    output ttw_pkg::cfg_t                            cfg
);

    ttw_pkg::cfg_t cfg_reg;
    ttw_pkg::cfg_t cfg_next;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ttw_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                ttw_pkg::REG_COLUMNS:      cfg_next.screen_columns = pwdata[7:0];
                ttw_pkg::REG_ROWS:         cfg_next.screen_rows    = pwdata[6:0];
                ttw_pkg::REG_COLOUR:       cfg_next.text_colour    = pwdata[7:0];
                ttw_pkg::REG_BLINK_ENABLE: cfg_next.blink_enable   = pwdata[0];
                ttw_pkg::REG_BLINK_PERIOD: cfg_next.blink_period   = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ttw_pkg::REG_COLUMNS:      prdata = 32'(cfg_reg.screen_columns);
            ttw_pkg::REG_ROWS:         prdata = 32'(cfg_reg.screen_rows);
            ttw_pkg::REG_COLOUR:       prdata = 32'(cfg_reg.text_colour);
            ttw_pkg::REG_BLINK_ENABLE: prdata = 32'(cfg_reg.blink_enable);
            ttw_pkg::REG_BLINK_PERIOD: prdata = 32'(cfg_reg.blink_period);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_columns <= ttw_pkg::RST_COLUMNS;
            cfg_reg.screen_rows    <= ttw_pkg::RST_ROWS;
            cfg_reg.text_colour    <= ttw_pkg::RST_COLOUR;
            cfg_reg.blink_enable   <= ttw_pkg::RST_BLINK_ENABLE;
            cfg_reg.blink_period   <= ttw_pkg::RST_BLINK_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ttw_ctrl.sv
// Sequencing state machine of the text terminal writer.
`default_nettype none

module ttw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  ttw_pkg::ctl_stat_t      stat,
    output ttw_pkg::ctl_cmd_t       ctl
);

    typedef enum logic [9:0] {
        S_INIT   = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_EXEC   = 10'b00_0000_0100,
        S_PRINT2 = 10'b00_0000_1000,
        S_READ   = 10'b00_0001_0000,
        S_COPY   = 10'b00_0010_0000,
        S_DRAIN  = 10'b00_0100_0000,
        S_FILL   = 10'b00_1000_0000,
        S_CLEAR  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second_pend_reg;
    logic   second_pend_next;
    logic   print_scroll;

    // A printed cell scrolls when it wraps off the last column of the last row
    assign print_scroll = stat.at_last_col && stat.at_last_row;

    always_comb
    begin
        state_next       = state_reg;
        second_pend_next = second_pend_reg;
        in_ready         = (state_reg == S_IDLE) || ((state_reg == S_DONE) && stat.out_free);

        ctl            = '0;
        ctl.cur_op     = ttw_pkg::CUR_HOLD;
        ctl.wr_sel     = ttw_pkg::WR_NONE;
        ctl.rd_sel     = ttw_pkg::RD_CELL;
        ctl.walk_op    = ttw_pkg::WALK_HOLD;
        ctl.blink_op   = ttw_pkg::BLINK_HOLD;
        ctl.item_load  = in_valid && in_ready;

        case (state_reg)
            S_INIT:
            begin
                ctl.wr_sel  = ttw_pkg::WR_INIT;
                ctl.walk_op = ttw_pkg::WALK_STEP_FULL;
                if (stat.walk_end_init)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.cmd)
                    ttw_pkg::CMD_PUT:
                    begin
                        ctl.blink_op = ttw_pkg::BLINK_RESTART;
                        state_next   = S_DONE;
                        if (stat.is_cr)
                        begin
                            ctl.cur_op = ttw_pkg::CUR_COL0;
                        end
                        else if (stat.is_lf)
                        begin
                            ctl.cur_op = ttw_pkg::CUR_DOWN;
                            if (stat.at_last_row)
                            begin
                                ctl.walk_op = ttw_pkg::WALK_START;
                                state_next  = stat.last_row_zero ? S_FILL : S_COPY;
                            end
                        end
                        else if (stat.is_bs)
                        begin
                            ctl.cur_op = ttw_pkg::CUR_LEFT;
                        end
                        else
                        begin
                            ctl.cur_op = ttw_pkg::CUR_ADV;
                            if (stat.is_ctrl)
                            begin
                                ctl.wr_sel       = ttw_pkg::WR_CARET;
                                second_pend_next = 1'b1;
                                state_next       = S_PRINT2;
                            end
                            else
                            begin
                                ctl.wr_sel = ttw_pkg::WR_CHAR;
                            end
                            if (print_scroll)
                            begin
                                ctl.walk_op = ttw_pkg::WALK_START;
                                state_next  = stat.last_row_zero ? S_FILL : S_COPY;
                            end
                        end
                    end
                    ttw_pkg::CMD_READ:
                    begin
                        ctl.cur_op = ttw_pkg::CUR_CLAMP;
                        ctl.rd_sel = ttw_pkg::RD_CELL;
                        state_next = S_READ;
                    end
                    ttw_pkg::CMD_CLEAR:
                    begin
                        ctl.cur_op  = ttw_pkg::CUR_HOME;
                        ctl.walk_op = ttw_pkg::WALK_START;
                        state_next  = S_CLEAR;
                    end
                    default:
                    begin
                        ctl.cur_op   = ttw_pkg::CUR_CLAMP;
                        ctl.blink_op = ttw_pkg::BLINK_TICK;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_PRINT2:
            begin
                ctl.wr_sel       = ttw_pkg::WR_CARET2;
                ctl.cur_op       = ttw_pkg::CUR_ADV;
                second_pend_next = 1'b0;
                state_next       = S_DONE;
                if (print_scroll)
                begin
                    ctl.walk_op = ttw_pkg::WALK_START;
                    state_next  = stat.last_row_zero ? S_FILL : S_COPY;
                end
            end
            S_READ:
            begin
                ctl.rd_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_COPY:
            begin
                ctl.rd_sel    = ttw_pkg::RD_COPY;
                ctl.copy_step = 1'b1;
                ctl.walk_op   = ttw_pkg::WALK_STEP;
                if (stat.walk_end_copy)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last copy write lands here; rewind for the bottom line
                ctl.walk_op = ttw_pkg::WALK_START;
                state_next  = S_FILL;
            end
            S_FILL:
            begin
                ctl.wr_sel  = ttw_pkg::WR_FILL;
                ctl.walk_op = ttw_pkg::WALK_STEP;
                if (stat.walk_end_col)
                begin
                    state_next = second_pend_reg ? S_PRINT2 : S_DONE;
                end
            end
            S_CLEAR:
            begin
                ctl.wr_sel  = ttw_pkg::WR_CLEAR;
                ctl.walk_op = ttw_pkg::WALK_STEP;
                if (stat.walk_end_clear)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = in_valid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            second_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            second_pend_reg <= second_pend_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ttw_datapath.sv
// Cursor, blink, cell store walker and result register of the text terminal writer.
`default_nettype none

module ttw_datapath #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ttw_pkg::cfg_t      cfg,
    input  ttw_pkg::ctl_cmd_t  ctl,
    output ttw_pkg::ctl_stat_t stat,
    input  wire logic [1:0]    in_cmd,
    input  wire logic [7:0]    in_char,
    input  wire logic [5:0]    in_row,
    input  wire logic [6:0]    in_col,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [6:0]         out_col,
    output logic [5:0]         out_row,
    output logic               out_shown,
    output logic [7:0]         out_char,
    output logic [7:0]         out_colour
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SAT_W  = 10;
    localparam int CW     = ttw_pkg::CELL_W;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c);
    endfunction

    // Held item
    logic [1:0] item_cmd_reg;
    logic [7:0] item_char_reg;
    logic [5:0] item_row_reg;
    logic [6:0] item_col_reg;

    // Cursor and blink
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic             blink_phase_reg, blink_phase_next;
    logic [15:0]      blink_count_reg, blink_count_next;

    // Store walker and copy write-behind
    logic [COL_W-1:0]  wcol_reg, wcol_next;
    logic [ROW_W-1:0]  wrow_reg, wrow_next;
    logic [ROW_W-1:0]  wrow_p1;
    logic [COL_W-1:0]  walk_lim;
    logic              cp_wr_reg;
    logic [ADDR_W-1:0] cp_addr_reg;

    // Read result and output register
    logic [CW-1:0] rd_cell_reg;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    out_col_reg;
    logic [5:0]    out_row_reg;
    logic          out_shown_reg;
    logic [7:0]    out_char_reg;
    logic [7:0]    out_colour_reg;

    // Screen size, clamped cursor
    logic [SAT_W-1:0] cols_ext, rows_ext, last_col_w, last_row_w;
    logic [COL_W-1:0] last_col, cc, cc_adv;
    logic [ROW_W-1:0] last_row, cr, cr_down;
    logic             rd_ok;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0]     ram_wdata, ram_rdata;

    assign cols_ext   = SAT_W'(cfg.screen_columns);
    assign rows_ext   = SAT_W'(cfg.screen_rows);
    assign last_col_w = (cols_ext == '0) ? '0 :
                        (cols_ext > SAT_W'(MAX_COLUMNS)) ? SAT_W'(MAX_COLUMNS - 1) :
                        cols_ext - SAT_W'(1);
    assign last_row_w = (rows_ext == '0) ? '0 :
                        (rows_ext > SAT_W'(MAX_ROWS)) ? SAT_W'(MAX_ROWS - 1) :
                        rows_ext - SAT_W'(1);
    assign last_col   = COL_W'(last_col_w);
    assign last_row   = ROW_W'(last_row_w);

    // Clamp the cursor into the area in use
    assign cc      = (cur_col_reg > last_col) ? last_col : cur_col_reg;
    assign cr      = (cur_row_reg > last_row) ? last_row : cur_row_reg;
    assign cr_down = (cr == last_row) ? cr : cr + ROW_W'(1);
    assign cc_adv  = cc + COL_W'(1);

    assign wrow_p1  = wrow_reg + ROW_W'(1);
    assign walk_lim = (ctl.walk_op == ttw_pkg::WALK_STEP_FULL) ? COL_W'(MAX_COLUMNS - 1) : last_col;

    assign rd_ok = (SAT_W'(item_row_reg) <= last_row_w) && (SAT_W'(item_col_reg) <= last_col_w);

    always_comb
    begin
        stat.cmd            = item_cmd_reg;
        stat.is_cr          = (item_char_reg == ttw_pkg::CHAR_CR);
        stat.is_lf          = (item_char_reg == ttw_pkg::CHAR_LF);
        stat.is_bs          = (item_char_reg == ttw_pkg::CHAR_BS);
        stat.is_ctrl        = (item_char_reg < ttw_pkg::CHAR_SPACE);
        stat.at_last_col    = (cc == last_col);
        stat.at_last_row    = (cr == last_row);
        stat.last_row_zero  = (last_row == '0);
        stat.walk_end_col   = (wcol_reg == last_col);
        stat.walk_end_copy  = (wrow_p1 == last_row) && (wcol_reg == last_col);
        stat.walk_end_clear = (wrow_reg == last_row) && (wcol_reg == last_col);
        stat.walk_end_init  = (wrow_reg == ROW_W'(MAX_ROWS - 1)) &&
                              (wcol_reg == COL_W'(MAX_COLUMNS - 1));
        stat.out_free       = !out_valid_reg || out_ready;
    end

    // Cursor update
    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        case (ctl.cur_op)
            ttw_pkg::CUR_HOLD:
            begin
                cur_col_next = cur_col_reg;
                cur_row_next = cur_row_reg;
            end
            ttw_pkg::CUR_CLAMP:
            begin
                cur_col_next = cc;
                cur_row_next = cr;
            end
            ttw_pkg::CUR_HOME:
            begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
            ttw_pkg::CUR_COL0:
            begin
                cur_col_next = '0;
                cur_row_next = cr;
            end
            ttw_pkg::CUR_LEFT:
            begin
                cur_col_next = (cc == '0) ? cc : cc - COL_W'(1);
                cur_row_next = cr;
            end
            ttw_pkg::CUR_DOWN:
            begin
                cur_col_next = cc;
                cur_row_next = cr_down;
            end
            ttw_pkg::CUR_ADV:
            begin
                if (cc == last_col)
                begin
                    cur_col_next = '0;
                    cur_row_next = cr_down;
                end
                else
                begin
                    cur_col_next = cc_adv;
                    cur_row_next = cr;
                end
            end
            default:
            begin
                cur_col_next = cur_col_reg;
                cur_row_next = cur_row_reg;
            end
        endcase
    end

    // Blink phase and count
    always_comb
    begin
        blink_phase_next = blink_phase_reg;
        blink_count_next = blink_count_reg;
        case (ctl.blink_op)
            ttw_pkg::BLINK_RESTART:
            begin
                blink_phase_next = 1'b1;
                blink_count_next = '0;
            end
            ttw_pkg::BLINK_TICK:
            begin
                if (!cfg.blink_enable)
                begin
                    blink_phase_next = 1'b1;
                end
                else if (blink_count_reg >= cfg.blink_period)
                begin
                    blink_phase_next = !blink_phase_reg;
                    blink_count_next = '0;
                end
                else
                begin
                    blink_count_next = blink_count_reg + 16'd1;
                end
            end
            default:
            begin
                blink_phase_next = blink_phase_reg;
                blink_count_next = blink_count_reg;
            end
        endcase
    end

    // Walker over the store, row by row
    always_comb
    begin
        wcol_next = wcol_reg;
        wrow_next = wrow_reg;
        case (ctl.walk_op)
            ttw_pkg::WALK_START:
            begin
                wcol_next = '0;
                wrow_next = '0;
            end
            ttw_pkg::WALK_STEP, ttw_pkg::WALK_STEP_FULL:
            begin
                if (wcol_reg == walk_lim)
                begin
                    wcol_next = '0;
                    wrow_next = wrow_p1;
                end
                else
                begin
                    wcol_next = wcol_reg + COL_W'(1);
                end
            end
            default:
            begin
                wcol_next = wcol_reg;
                wrow_next = wrow_reg;
            end
        endcase
    end

    // Store write port: a pending copy write goes first
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cell_addr(cr, cc);
        ram_wdata = {cfg.text_colour, item_char_reg};
        if (cp_wr_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = cp_addr_reg;
            ram_wdata = ram_rdata;
        end
        else
        begin
            case (ctl.wr_sel)
                ttw_pkg::WR_CHAR:
                begin
                    ram_we = 1'b1;
                end
                ttw_pkg::WR_CARET:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {cfg.text_colour, ttw_pkg::CHAR_CARET};
                end
                ttw_pkg::WR_CARET2:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {cfg.text_colour, ttw_pkg::CHAR_AT + item_char_reg};
                end
                ttw_pkg::WR_FILL:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(last_row, wcol_reg);
                    ram_wdata = {cfg.text_colour, ttw_pkg::CHAR_SPACE};
                end
                ttw_pkg::WR_CLEAR:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(wrow_reg, wcol_reg);
                    ram_wdata = {cfg.text_colour, ttw_pkg::CHAR_SPACE};
                end
                ttw_pkg::WR_INIT:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(wrow_reg, wcol_reg);
                    ram_wdata = {ttw_pkg::RESET_COLOUR, ttw_pkg::CHAR_SPACE};
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    assign ram_raddr = (ctl.rd_sel == ttw_pkg::RD_COPY) ?
                       cell_addr(wrow_p1, wcol_reg) :
                       cell_addr(ROW_W'(item_row_reg), COL_W'(item_col_reg));

    ttw_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            blink_phase_reg <= 1'b1;
            blink_count_reg <= '0;
            wcol_reg        <= '0;
            wrow_reg        <= '0;
            cp_wr_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            blink_phase_reg <= blink_phase_next;
            blink_count_reg <= blink_count_next;
            wcol_reg        <= wcol_next;
            wrow_reg        <= wrow_next;
            cp_wr_reg       <= ctl.copy_step;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.item_load)
        begin
            item_cmd_reg  <= in_cmd;
            item_char_reg <= in_char;
            item_row_reg  <= in_row;
            item_col_reg  <= in_col;
        end
        // destination of the cell read this cycle
        cp_addr_reg <= cell_addr(wrow_reg, wcol_reg);
        if (ctl.rd_capture)
        begin
            rd_cell_reg <= rd_ok ? ram_rdata : '0;
        end
        if (ctl.out_load)
        begin
            out_col_reg    <= 7'(cur_col_reg);
            out_row_reg    <= 6'(cur_row_reg);
            out_shown_reg  <= blink_phase_reg;
            out_char_reg   <= (item_cmd_reg == ttw_pkg::CMD_READ) ? rd_cell_reg[7:0] : '0;
            out_colour_reg <= (item_cmd_reg == ttw_pkg::CMD_READ) ? rd_cell_reg[15:8] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign out_shown  = out_shown_reg;
    assign out_char   = out_char_reg;
    assign out_colour = out_colour_reg;

endmodule

`default_nettype wire

// File: hdl/text_terminal_writer.sv
// Top level of the text terminal writer: stream ports, register port, controller and datapath.
`default_nettype none

// Character-cell terminal that keeps a MAX_ROWS x MAX_COLUMNS store of character and
// colour bytes, of which the top-left screen_rows x screen_columns area is in use. Each
// input item carries a command in s_axis_tuser: put character (CR, LF, BS, caret notation
// for other control codes, printable bytes written in text_colour with wrap and scroll),
// read cell, clear screen or blink tick. Every item returns exactly one result item with
// the cursor position, the blink phase and, for a read, the cell contents. After reset the
// block runs a clearing pass over all MAX_ROWS*MAX_COLUMNS cells (8192 at the defaults) that fills
// the store with spaces in colour 1; no item is accepted during it, though register writes
// are. A scroll copies each row of the area in use but the top one up by one row, then
// blanks the bottom row, which is all it does when one row is in use; a clear blanks the
// whole area in use. These walks are set by the single write port of the cell store, which
// moves one cell per cycle. A finished result waits in an output register, so the next item
// is taken while it is still unclaimed; the item after that waits until it is taken.
module text_terminal_writer #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input items
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [23:0]                        s_axis_tdata,  // char_byte, cell_row, cell_col
    input  wire logic [1:0]                         s_axis_tuser,  // cmd
    // Result items
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // cursor_col, cursor_row, cursor_shown, read_char, read_colour
    output logic [31:0]                             m_axis_tdata,
    // Register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ttw_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [ttw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [ttw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    ttw_pkg::cfg_t      cfg;
    ttw_pkg::ctl_cmd_t  ctl;
    ttw_pkg::ctl_stat_t stat;

    logic [6:0] out_col;
    logic [5:0] out_row;
    logic       out_shown;
    logic [7:0] out_char;
    logic [7:0] out_colour;

    ttw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller decides the step; item acceptance is its in_ready
    ttw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ttw_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .ctl        (ctl),
        .stat       (stat),
        .in_cmd     (s_axis_tuser),
        .in_char    (s_axis_tdata[7:0]),
        .in_row     (s_axis_tdata[13:8]),
        .in_col     (s_axis_tdata[20:14]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_col    (out_col),
        .out_row    (out_row),
        .out_shown  (out_shown),
        .out_char   (out_char),
        .out_colour (out_colour)
    );

    // Pack the result fields, lowest first, zero pad to a whole byte
    assign m_axis_tdata = {2'b00, out_colour, out_char, out_shown, out_row, out_col};

endmodule

`default_nettype wire

// File: bench/text_terminal_writer_tb.sv
// Self-checking bench for the text terminal writer: directed and random items against a predictor.
module text_terminal_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLUMNS    = 128;
    localparam int MAX_ROWS       = 64;
    localparam int STORE_DEPTH    = MAX_COLUMNS * MAX_ROWS;
    // A clear or a scroll of the full 128x64 area and the clearing pass after reset are the
    // longest quiet stretches; allow several times the worst of them.
    localparam int WATCHDOG_LIMIT = 50000;

    // One result item, packed as on m_axis_tdata (cursor_col in the lowest bits)
    typedef struct packed {
        logic [7:0] read_colour;
        logic [7:0] read_char;
        logic       cursor_shown;
        logic [5:0] cursor_row;
        logic [6:0] cursor_col;
    } term_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // char_byte, cell_row, cell_col
    logic [1:0]  s_axis_tuser = ttw_pkg::CMD_TICK;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // cursor_col, cursor_row, cursor_shown, read_char, read_colour
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ttw_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ttw_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [ttw_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    // Predicted terminal state: register copy, cell stores, cursor and blink
    ttw_pkg::cfg_t cfg;
    logic [7:0]  screen_chars   [STORE_DEPTH];
    logic [7:0]  screen_colours [STORE_DEPTH];
    int          cursor_col;
    int          cursor_row;
    logic        cursor_shown;
    logic [15:0] blink_ticks;

    term_report_t reports_due[$];
    term_report_t report_got;
    term_report_t report_want;

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles   = 0;

    text_terminal_writer #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate the programmed sizes to what the store can hold
    function automatic int used_columns();
        if (cfg.screen_columns == 0)
            return 1;
        if (cfg.screen_columns > MAX_COLUMNS)
            return MAX_COLUMNS;
        return int'(cfg.screen_columns);
    endfunction

    function automatic int used_rows();
        if (cfg.screen_rows == 0)
            return 1;
        if (cfg.screen_rows > MAX_ROWS)
            return MAX_ROWS;
        return int'(cfg.screen_rows);
    endfunction

    function automatic void blank_line(int row, int cols);
        for (int c = 0; c < cols; c++)
        begin
            screen_chars[row * MAX_COLUMNS + c]   = ttw_pkg::CHAR_SPACE;
            screen_colours[row * MAX_COLUMNS + c] = cfg.text_colour;
        end
    endfunction

    // Move the in-use lines up by one and blank the last; cells right of the area stay put
    function automatic void scroll_screen(int cols, int rows);
        for (int r = 0; r + 1 < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                screen_chars[r * MAX_COLUMNS + c]   = screen_chars[(r + 1) * MAX_COLUMNS + c];
                screen_colours[r * MAX_COLUMNS + c] = screen_colours[(r + 1) * MAX_COLUMNS + c];
            end
        end
        blank_line(rows - 1, cols);
    endfunction

    function automatic void line_down(int cols, int rows);
        if (cursor_row + 1 >= rows)
            scroll_screen(cols, rows);
        else
            cursor_row++;
    endfunction

    function automatic void print_char(logic [7:0] code, int cols, int rows);
        int addr;
        addr = cursor_row * MAX_COLUMNS + cursor_col;
        screen_chars[addr]   = code;
        screen_colours[addr] = cfg.text_colour;
        if (cursor_col + 1 >= cols)
        begin
            cursor_col = 0;
            line_down(cols, rows);
        end
        else
            cursor_col++;
    endfunction

    // Apply one accepted item to the predicted state and return its report
    function automatic term_report_t step_terminal(logic [1:0] cmd, logic [7:0] ch,
                                                   logic [5:0] read_row, logic [6:0] read_col);
        int cols;
        int rows;
        term_report_t rep;
        cols = used_columns();
        rows = used_rows();
        rep  = '0;
        // Pull a cursor left outside a shrunken area back to its last cell
        if (cursor_col >= cols)
            cursor_col = cols - 1;
        if (cursor_row >= rows)
            cursor_row = rows - 1;
        case (cmd)
            ttw_pkg::CMD_PUT:
            begin
                if (ch == ttw_pkg::CHAR_CR)
                    cursor_col = 0;
                else if (ch == ttw_pkg::CHAR_LF)
                    line_down(cols, rows);
                else if (ch == ttw_pkg::CHAR_BS)
                begin
                    if (cursor_col > 0)
                        cursor_col--;
                end
                else if (ch < ttw_pkg::CHAR_SPACE)
                begin
                    print_char(ttw_pkg::CHAR_CARET, cols, rows);
                    print_char(ttw_pkg::CHAR_AT + ch, cols, rows);
                end
                else
                    print_char(ch, cols, rows);
                cursor_shown = 1'b1;
                blink_ticks  = '0;
            end
            ttw_pkg::CMD_READ:
            begin
                if (read_row < rows && read_col < cols)
                begin
                    rep.read_char   = screen_chars[read_row * MAX_COLUMNS + read_col];
                    rep.read_colour = screen_colours[read_row * MAX_COLUMNS + read_col];
                end
            end
            ttw_pkg::CMD_CLEAR:
            begin
                for (int r = 0; r < rows; r++)
                    blank_line(r, cols);
                cursor_col = 0;
                cursor_row = 0;
            end
            ttw_pkg::CMD_TICK:
            begin
                if (cfg.blink_enable)
                begin
                    if (blink_ticks >= cfg.blink_period)
                    begin
                        cursor_shown = ~cursor_shown;
                        blink_ticks  = '0;
                    end
                    else
                        blink_ticks = blink_ticks + 16'd1;
                end
                else
                    cursor_shown = 1'b1;
            end
            default:
                ;
        endcase
        rep.cursor_col   = 7'(cursor_col);
        rep.cursor_row   = 6'(cursor_row);
        rep.cursor_shown = cursor_shown;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every accepted result with the oldest prediction waiting
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("result %h arrived with no item waiting", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                report_want = reports_due.pop_front();
                report_got  = term_report_t'(m_axis_tdata[29:0]);
                check_field("cursor_col", 8'(report_want.cursor_col),
                            8'(report_got.cursor_col));
                check_field("cursor_row", 8'(report_want.cursor_row),
                            8'(report_got.cursor_row));
                check_field("cursor_shown", 8'(report_want.cursor_shown),
                            8'(report_got.cursor_shown));
                check_field("read_char", report_want.read_char, report_got.read_char);
                check_field("read_colour", report_want.read_colour, report_got.read_colour);
            end
        end
    end

    // Receiver: hold off completely while a hold is pending, else stall at random
    always @(posedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when neither stream moves an item for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[text_terminal_writer] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one item, idling first at random; predict its report at acceptance.
    // Leave tvalid high afterwards so back-to-back items need no drop in between.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [5:0] read_row, input logic [6:0] read_col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, read_col, read_row, ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        reports_due.push_back(step_terminal(cmd, ch, read_row, read_col));
    endtask

    // Drop tvalid and hold until every predicted result has come back
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (index)
            ttw_pkg::REG_COLUMNS:      cfg.screen_columns = value[7:0];
            ttw_pkg::REG_ROWS:         cfg.screen_rows    = value[6:0];
            ttw_pkg::REG_COLOUR:       cfg.text_colour    = value[7:0];
            ttw_pkg::REG_BLINK_ENABLE: cfg.blink_enable   = value[0];
            ttw_pkg::REG_BLINK_PERIOD: cfg.blink_period   = value[15:0];
            default:                   ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program all five registers; only call with the block idle
    task automatic set_screen(input int cols, input int rows, input int colour,
                              input int blink_on, input int period);
        write_register(ttw_pkg::REG_COLUMNS, cols);
        write_register(ttw_pkg::REG_ROWS, rows);
        write_register(ttw_pkg::REG_COLOUR, colour);
        write_register(ttw_pkg::REG_BLINK_ENABLE, blink_on);
        write_register(ttw_pkg::REG_BLINK_PERIOD, period);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default 80x25 screen: store contents after reset, every character class
    task automatic test_control_codes();
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_READ, 8'hFF, 6'd63, 7'd127);     // outside the area
        send_item(ttw_pkg::CMD_PUT, 8'h48, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_PUT, 8'hFF, 6'd63, 7'd127);
        send_item(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_BS, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_CR, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_BS, 6'd0, 7'd0);  // already at column 0
        send_item(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_LF, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_PUT, 8'h00, 6'd0, 7'd0);         // caret notation, lowest code
        send_item(ttw_pkg::CMD_PUT, 8'h1F, 6'd0, 7'd0);         // caret notation, highest code
        send_item(ttw_pkg::CMD_TICK, 8'h00, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd1, 7'd3);
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd24, 7'd79);      // last in-use cell
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd25, 7'd0);       // one row below the area
        drain_reports();
    endtask

    // Shrink the screen under the cursor, wrap, scroll, and walk the blink phase
    task automatic test_small_screen();
        set_screen(3, 2, 8'hC3, 1, 1);
        send_item(ttw_pkg::CMD_PUT, 8'h78, 6'd0, 7'd0);    // cursor clamped, then wraps and scrolls
        send_item(ttw_pkg::CMD_TICK, 8'h00, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_TICK, 8'h00, 6'd0, 7'd0);   // phase toggles to hidden
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd0, 7'd2);   // read keeps the phase
        send_item(ttw_pkg::CMD_CLEAR, 8'h00, 6'd0, 7'd0);  // clear keeps the phase
        send_item(ttw_pkg::CMD_PUT, 8'h01, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd5, 7'd5);
        drain_reports();
    endtask

    // Sizes below and above range saturate; blink disabled forces shown
    task automatic test_size_limits();
        set_screen(0, 0, 8'h5A, 0, 0);
        send_item(ttw_pkg::CMD_TICK, 8'h00, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_PUT, 8'h7A, 6'd0, 7'd0);    // 1x1: write then scroll it away
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_LF, 6'd0, 7'd0);
        drain_reports();
        set_screen(255, 127, 8'h00, 1, 65535);
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd63, 7'd127);     // untouched since reset
        send_item(ttw_pkg::CMD_CLEAR, 8'h00, 6'd0, 7'd0);
        send_item(ttw_pkg::CMD_READ, 8'h00, 6'd63, 7'd127);
        drain_reports();
    endtask

    // Random items over a random screen setting
    task automatic test_random_text(input int phase, input int items,
                                    input int idle_pct, input int stall_pct);
        int cols;
        int rows;
        int period;
        int pick;
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [5:0] read_row;
        logic [6:0] read_col;
        drain_reports();
        cols = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16);
        rows = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        // One phase on the full store, a few on the row and column extremes
        if (phase == 3)
        begin
            cols = 255;
            rows = 64;
        end
        else if (phase == 5)
            rows = 127;
        else if (phase == 7)
        begin
            cols = 128;
            rows = 1;
        end
        case ($urandom_range(5))
            0:       period = 0;
            1:       period = 65535;
            default: period = $urandom_range(1, 4);
        endcase
        set_screen(cols, rows, $urandom_range(255), $urandom_range(3) != 0, period);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < items; n++)
        begin
            ch       = $urandom_range(255);
            read_row = $urandom_range(63);
            read_col = $urandom_range(127);
            pick     = $urandom_range(99);
            if (pick < 55)
            begin
                cmd  = ttw_pkg::CMD_PUT;
                pick = $urandom_range(99);
                if (pick < 60)
                    ch = $urandom_range(32, 255);
                else if (pick < 85)
                    ch = (pick < 70) ? ttw_pkg::CHAR_CR :
                         (pick < 78) ? ttw_pkg::CHAR_LF : ttw_pkg::CHAR_BS;
                else
                    ch = $urandom_range(31);
            end
            else if (pick < 78)
            begin
                cmd = ttw_pkg::CMD_READ;
                // Mostly aim inside the area or just past its edge
                if ($urandom_range(3) != 0)
                begin
                    read_row = 6'(($urandom_range(used_rows()) > 63) ? 63 :
                                  $urandom_range(used_rows()));
                    read_col = 7'(($urandom_range(used_columns()) > 127) ? 127 :
                                  $urandom_range(used_columns()));
                end
            end
            else if (pick < 82)
                cmd = ttw_pkg::CMD_CLEAR;
            else
                cmd = ttw_pkg::CMD_TICK;
            send_item(cmd, ch, read_row, read_col);
        end
    endtask

    // Stop the receiver long enough for the block to fill and stall its input,
    // then let the sender wait for every result before going on
    task automatic test_backpressure();
        drain_reports();
        set_screen(6, 3, 8'h3C, 1, 2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        rx_hold_cycles = 400;
        @(posedge clk);
        for (int n = 0; n < 30; n++)
            send_item(n % 7 == 6 ? ttw_pkg::CMD_READ : ttw_pkg::CMD_PUT, 8'(8'h41 + n),
                      6'(n % 4), 7'(n % 8));
        drain_reports();
        for (int n = 0; n < 15; n++)
            send_item(ttw_pkg::CMD_PUT, ttw_pkg::CHAR_LF, 6'd0, 7'd0);
        drain_reports();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Reset state of the predictor matches the block after its clearing pass
        cfg = {ttw_pkg::RST_COLUMNS, ttw_pkg::RST_ROWS, ttw_pkg::RST_COLOUR,
               ttw_pkg::RST_BLINK_ENABLE, ttw_pkg::RST_BLINK_PERIOD};
        for (int a = 0; a < STORE_DEPTH; a++)
        begin
            screen_chars[a]   = ttw_pkg::CHAR_SPACE;
            screen_colours[a] = ttw_pkg::RESET_COLOUR;
        end
        cursor_col   = 0;
        cursor_row   = 0;
        cursor_shown = 1'b1;
        blink_ticks  = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_control_codes();
        test_small_screen();
        test_size_limits();
        test_backpressure();
        // Cycle through the idling modes twice: none, sender, receiver, both
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:       test_random_text(p, 95, 0, 0);
                1:       test_random_text(p, 95, 75, 0);
                2:       test_random_text(p, 95, 0, 75);
                default: test_random_text(p, 95, 8, 8);
            endcase
        end

        drain_reports();
        // Give a stray extra result time to show up
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("[text_terminal_writer] OK");
        else
            $display("[text_terminal_writer] ERROR");
        $finish;
    end

endmodule
